// ===== sv/fprc_pkg.sv =====
// Shared constants, types and control structs for the freed page range coalescer.
package fprc_pkg;

  localparam int RANGE_SLOTS     = 8;
  localparam int PAGE_BITS       = 52;
  localparam int COUNT_BITS      = 8;
  localparam int SLOT_IDX_BITS   = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;

  typedef logic [PAGE_BITS-1:0]     page_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [SLOT_IDX_BITS-1:0] slot_idx_t;
  typedef logic [RANGE_SLOTS-1:0]   slot_vec_t;

  localparam count_t THRESHOLD_RESET = count_t'(128);

  // Controller to datapath commands.
  typedef struct packed {
    logic load_page;    // capture the incoming page number
    logic place;        // extend, fill or evict for the captured page
    logic flush_start;  // clear the held count, start releasing slots
    logic flush_step;   // release the lowest occupied slot
  } fprc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic page_bad;     // page is zero or all ones: ignored
    logic evict;        // no slot matches and none is empty
    logic held_ge_thr;  // held count at or above threshold
    logic occ_any;      // at least one slot occupied
    logic out_last;     // registered result is the last of its run
  } fprc_stat_t;

endpackage

// ===== sv/fprc_if.sv =====
// Valid/ready channel interfaces for freed pages, unmap requests and threshold writes.
interface fprc_page_if;
  logic                 valid;
  logic                 ready;
  fprc_pkg::page_t      freed_page;
  modport source (output valid, output freed_page, input ready);
  modport sink   (input valid, input freed_page, output ready);
endinterface

interface fprc_unmap_if;
  logic                 valid;
  logic                 ready;
  fprc_pkg::page_t      unmap_first_page;
  fprc_pkg::count_t     unmap_page_count;
  logic                 last_of_run;
  modport source (output valid, output unmap_first_page, output unmap_page_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input unmap_first_page, input unmap_page_count,
                  input last_of_run, output ready);
endinterface

interface fprc_cfg_if;
  logic                 valid;
  logic                 ready;
  fprc_pkg::count_t     flush_threshold;
  modport source (output valid, output flush_threshold, input ready);
  modport sink   (input valid, input flush_threshold, output ready);
endinterface

// ===== sv/fprc_datapath.sv =====
// Slot table, held page count, threshold register and result register.
module fprc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  fprc_pkg::fprc_cmd_t cmd,
  output fprc_pkg::fprc_stat_t stat,
  input  fprc_pkg::page_t     freed_page,
  input  logic                cfg_we,
  input  fprc_pkg::count_t    cfg_data,
  output fprc_pkg::page_t     out_first_page,
  output fprc_pkg::count_t    out_page_count,
  output logic                out_last
);
  import fprc_pkg::*;

  page_t     range_first [RANGE_SLOTS];
  page_t     range_limit [RANGE_SLOTS];
  count_t    held_pages;
  count_t    flush_threshold;
  page_t     page_q;

  page_t     page_inc;
  slot_vec_t occ;
  slot_vec_t ext_hi;
  slot_vec_t ext_lo;
  logic      hit_any;
  logic      empty_any;
  slot_idx_t hit_idx;
  slot_idx_t empty_idx;
  slot_idx_t occ_idx;
  slot_vec_t occ_rest;
  page_t     evict_len;
  count_t    held_evict;
  page_t     flush_len;

  assign page_inc = page_q + page_t'(1);

  always_comb begin
    for (int s = 0; s < RANGE_SLOTS; s++) begin
      occ[s]    = (range_limit[s] != '0);
      ext_hi[s] = occ[s] && (range_limit[s] == page_q);
      ext_lo[s] = occ[s] && (range_first[s] == page_inc);
    end
  end

  // First matching, first empty and first occupied slot.
  always_comb begin
    hit_any   = 1'b0;
    empty_any = 1'b0;
    hit_idx   = '0;
    empty_idx = '0;
    occ_idx   = '0;
    for (int s = RANGE_SLOTS - 1; s >= 0; s--) begin
      if (ext_hi[s] || ext_lo[s]) begin
        hit_any = 1'b1;
        hit_idx = slot_idx_t'(s);
      end
      if (!occ[s]) begin
        empty_any = 1'b1;
        empty_idx = slot_idx_t'(s);
      end
      if (occ[s]) begin
        occ_idx = slot_idx_t'(s);
      end
    end
  end

  always_comb begin
    occ_rest          = occ;
    occ_rest[occ_idx] = 1'b0;
  end

  assign evict_len  = range_limit[0] - range_first[0];
  assign held_evict = (evict_len > page_t'(held_pages))
                    ? count_t'(1)
                    : count_t'(held_pages - evict_len[COUNT_BITS-1:0] + count_t'(1));
  assign flush_len  = range_limit[occ_idx] - range_first[occ_idx];

  assign stat.page_bad    = (page_q == '0) || (page_q == '1);
  assign stat.evict       = !hit_any && !empty_any;
  assign stat.held_ge_thr = (held_pages >= flush_threshold);
  assign stat.occ_any     = |occ;
  assign stat.out_last    = out_last;

  always_ff @(posedge clk) begin
    if (cmd.load_page) begin
      page_q <= freed_page;
    end
    if (cmd.place) begin
      if (hit_any) begin
        if (ext_hi[hit_idx]) begin
          range_limit[hit_idx] <= page_inc;
        end else begin
          range_first[hit_idx] <= page_q;
        end
      end else if (empty_any) begin
        range_first[empty_idx] <= page_q;
        range_limit[empty_idx] <= page_inc;
      end else begin
        out_first_page <= range_first[0];
        out_page_count <= evict_len[COUNT_BITS-1:0];
        out_last       <= 1'b1;
        range_first[0] <= page_q;
        range_limit[0] <= page_inc;
      end
    end
    if (cmd.flush_step) begin
      out_first_page       <= range_first[occ_idx];
      out_page_count       <= flush_len[COUNT_BITS-1:0];
      out_last             <= (occ_rest == '0);
      range_limit[occ_idx] <= '0;
    end
    if (rst) begin
      for (int s = 0; s < RANGE_SLOTS; s++) begin
        range_limit[s] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_pages      <= '0;
      flush_threshold <= THRESHOLD_RESET;
    end else begin
      if (cfg_we) begin
        flush_threshold <= cfg_data;
      end
      if (cmd.place) begin
        if (hit_any || empty_any) begin
          held_pages <= held_pages + count_t'(1);
        end else begin
          held_pages <= held_evict;
        end
      end else if (cmd.flush_start) begin
        held_pages <= '0;
      end
    end
  end

endmodule

// ===== sv/fprc_ctrl.sv =====
// Sequencing state machine: accept, place, threshold check, flush and result handoff.
module fprc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fprc_pkg::fprc_cmd_t  cmd,
  input  fprc_pkg::fprc_stat_t stat
);
  import fprc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CHECK = 5'b00100,
    S_FLUSH = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load_page = in_valid;
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.page_bad) begin
          state_next = S_IDLE;
        end else begin
          cmd.place  = 1'b1;
          state_next = stat.evict ? S_EMIT : S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.held_ge_thr) begin
          cmd.flush_start = 1'b1;
          state_next      = S_FLUSH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (stat.occ_any) begin
          cmd.flush_step = 1'b1;
          state_next     = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          state_next = stat.out_last ? S_IDLE : S_FLUSH;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/freed_page_range_coalescer_core.sv =====
// A placed page with no flush passes through the scan and threshold check states before the block is idle again.
// An eviction presents its unmap request once the page is captured and the evicted range is in the result register.
// A flush releases one range at a time (slot select, then handoff), up to RANGE_SLOTS.
// One page is handled at a time; the slot scan and the flush walk set the rate.
// Reset (rst, synchronous): all slots empty, held count zero, threshold 128.
module freed_page_range_coalescer_core (
  input  logic               clk,
  input  logic               rst,
  fprc_page_if.sink          freed_in,
  fprc_unmap_if.source       unmap_out,
  fprc_cfg_if.sink           cfg
);
  import fprc_pkg::*;

  fprc_cmd_t  cmd;
  fprc_stat_t stat;

  // Threshold writes are always taken; the user must send them only while the block is idle (not enforced here).
  assign cfg.ready = 1'b1;

  // Controller: owns the handshakes and steps through scan, check and flush.
  fprc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (freed_in.valid),
    .in_ready  (freed_in.ready),
    .out_valid (unmap_out.valid),
    .out_ready (unmap_out.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: slot table compares in parallel; the result register holds one
  // unmap transaction until the sink takes it.
  fprc_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .freed_page     (freed_in.freed_page),
    .cfg_we         (cfg.valid),
    .cfg_data       (cfg.flush_threshold),
    .out_first_page (unmap_out.unmap_first_page),
    .out_page_count (unmap_out.unmap_page_count),
    .out_last       (unmap_out.last_of_run)
  );

endmodule
